// File: rtl/core/pidsc_pkg.sv
// shared types and register map for the pid speed controller
`timescale 1ns / 1ps

package pidsc_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int IDX_W   = 3;

    // register index, byte address is 4 * index
    localparam logic [IDX_W-1:0] REG_KP         = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI_DT      = 3'd1;
    localparam logic [IDX_W-1:0] REG_KD_PER_DT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SUM_LIMIT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRIVE_MIN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_DRIVE_MAX  = 3'd5;

    localparam int GAIN_W  = 32;
    localparam int LIMIT_W = 31;
    localparam int SPEED_W = 16;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int SUM_W   = 32;
    localparam int DRIVE_W = 32;
    localparam int ACC_W   = 64;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki_dt;
        logic [GAIN_W-1:0]  kd_per_dt;
        logic [LIMIT_W-1:0] error_sum_limit;
        logic [DRIVE_W-1:0] drive_min;
        logic [DRIVE_W-1:0] drive_max;
    } t_cfg;

endpackage

// File: rtl/core/pidsc_cfg_regs.sv
// apb register file holding gains, integral clamp and output limits
`timescale 1ns / 1ps

module pidsc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidsc_pkg::PADDR_W-1:0] paddr,
    input  logic [pidsc_pkg::PDATA_W-1:0] pwdata,
    output logic [pidsc_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output pidsc_pkg::t_cfg               o_cfg
);

    pidsc_pkg::t_cfg                r_cfg;
    logic [pidsc_pkg::IDX_W-1:0]    w_idx;
    logic                           w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[pidsc_pkg::PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                pidsc_pkg::REG_KP:         r_cfg.kp <= pwdata;
                pidsc_pkg::REG_KI_DT:      r_cfg.ki_dt <= pwdata;
                pidsc_pkg::REG_KD_PER_DT:  r_cfg.kd_per_dt <= pwdata;
                pidsc_pkg::REG_SUM_LIMIT:  r_cfg.error_sum_limit <=
                                               pwdata[pidsc_pkg::LIMIT_W-1:0];
                pidsc_pkg::REG_DRIVE_MIN:  r_cfg.drive_min <= pwdata;
                pidsc_pkg::REG_DRIVE_MAX:  r_cfg.drive_max <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            pidsc_pkg::REG_KP:         prdata = r_cfg.kp;
            pidsc_pkg::REG_KI_DT:      prdata = r_cfg.ki_dt;
            pidsc_pkg::REG_KD_PER_DT:  prdata = r_cfg.kd_per_dt;
            pidsc_pkg::REG_SUM_LIMIT:  prdata = {1'b0, r_cfg.error_sum_limit};
            pidsc_pkg::REG_DRIVE_MIN:  prdata = r_cfg.drive_min;
            pidsc_pkg::REG_DRIVE_MAX:  prdata = r_cfg.drive_max;
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/pid_speed_controller_unit.sv
// pid speed controller: error integrator, three gain products, output clamp
// pipeline from an accepted request to o_valid: error/integrator,
// products, sum and shift, output clamp, one register stage each
// throughput: one request per cycle while i_stall does not back up the pipe;
// the integrator update is a single add and clamp so back to back ticks chain through it
// reset (i_rst_n, synchronous): registers, integrator, last error, pipe empty
`timescale 1ns / 1ps

module pid_speed_controller_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pidsc_pkg::SPEED_W-1:0] i_target_speed,
    input  logic [pidsc_pkg::SPEED_W-1:0] i_measured_speed,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pidsc_pkg::DRIVE_W-1:0] o_drive,
    output logic                          o_limited,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidsc_pkg::PADDR_W-1:0] paddr,
    input  logic [pidsc_pkg::PDATA_W-1:0] pwdata,
    output logic [pidsc_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);

    localparam int SH_W = pidsc_pkg::ACC_W - FRAC_BITS;
    localparam int P_W  = pidsc_pkg::GAIN_W + pidsc_pkg::ERR_W;
    localparam int I_W  = pidsc_pkg::GAIN_W + pidsc_pkg::SUM_W;
    localparam int D_W  = pidsc_pkg::GAIN_W + pidsc_pkg::DIFF_W;

    pidsc_pkg::t_cfg w_cfg;

    pidsc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // pipeline advance, a stage moves when empty or when the next one moves
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_adv1, w_adv2, w_adv3, w_adv4;
    logic w_accept;

    assign w_adv4   = !r_v4 || !i_stall;
    assign w_adv3   = !r_v3 || w_adv4;
    assign w_adv2   = !r_v2 || w_adv3;
    assign w_adv1   = !r_v1 || w_adv2;
    assign o_stall  = !w_adv1;
    assign w_accept = i_valid && w_adv1;

    // stage 1: error, clamped integrator, error difference
    logic signed [pidsc_pkg::SUM_W-1:0]  r_error_sum;
    logic signed [pidsc_pkg::ERR_W-1:0]  r_last_error;
    logic signed [pidsc_pkg::ERR_W-1:0]  w_err;
    logic signed [pidsc_pkg::SUM_W:0]    w_sum_raw;
    logic signed [pidsc_pkg::SUM_W:0]    w_lim_pos;
    logic signed [pidsc_pkg::SUM_W:0]    w_lim_neg;
    logic signed [pidsc_pkg::SUM_W:0]    w_sum_sel;
    logic signed [pidsc_pkg::SUM_W-1:0]  w_sum;
    logic signed [pidsc_pkg::DIFF_W-1:0] w_diff;

    assign w_err = $signed({i_target_speed[pidsc_pkg::SPEED_W-1], i_target_speed})
                 - $signed({i_measured_speed[pidsc_pkg::SPEED_W-1], i_measured_speed});
    assign w_sum_raw = $signed({r_error_sum[pidsc_pkg::SUM_W-1], r_error_sum})
                     + (pidsc_pkg::SUM_W+1)'(w_err);
    assign w_lim_pos = $signed({2'b00, w_cfg.error_sum_limit});
    assign w_lim_neg = -w_lim_pos;

    always_comb begin
        priority if (w_sum_raw > w_lim_pos) begin
            w_sum_sel = w_lim_pos;
        end else if (w_sum_raw < w_lim_neg) begin
            w_sum_sel = w_lim_neg;
        end else begin
            w_sum_sel = w_sum_raw;
        end
    end

    assign w_sum  = w_sum_sel[pidsc_pkg::SUM_W-1:0];
    assign w_diff = pidsc_pkg::DIFF_W'(w_err) - pidsc_pkg::DIFF_W'(r_last_error);

    logic signed [pidsc_pkg::ERR_W-1:0]  r_err1;
    logic signed [pidsc_pkg::SUM_W-1:0]  r_sum1;
    logic signed [pidsc_pkg::DIFF_W-1:0] r_diff1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_accept) begin
                r_error_sum  <= w_sum;
                r_last_error <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_err1  <= w_err;
            r_sum1  <= w_sum;
            r_diff1 <= w_diff;
        end
    end

    // stage 2: the three gain products
    logic signed [P_W-1:0] w_p_prod, r_p_prod;
    logic signed [I_W-1:0] w_i_prod, r_i_prod;
    logic signed [D_W-1:0] w_d_prod, r_d_prod;

    assign w_p_prod = $signed(w_cfg.kp) * r_err1;
    assign w_i_prod = $signed(w_cfg.ki_dt) * r_sum1;
    assign w_d_prod = $signed(w_cfg.kd_per_dt) * r_diff1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_p_prod <= w_p_prod;
            r_i_prod <= w_i_prod;
            r_d_prod <= w_d_prod;
        end
    end

    // stage 3: term sum and floor shift (arithmetic shift is a floor)
    logic signed [pidsc_pkg::ACC_W-1:0] w_total;
    logic signed [pidsc_pkg::ACC_W-1:0] w_shifted;
    logic signed [SH_W-1:0]             r_acc;

    assign w_total   = pidsc_pkg::ACC_W'(r_p_prod) + pidsc_pkg::ACC_W'(r_i_prod)
                     + pidsc_pkg::ACC_W'(r_d_prod);
    assign w_shifted = w_total >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_acc <= w_shifted[SH_W-1:0];
        end
    end

    // stage 4: output clamp, max is checked first for inverted limits
    logic signed [SH_W-1:0]              w_max_ext;
    logic signed [SH_W-1:0]              w_min_ext;
    logic [pidsc_pkg::DRIVE_W-1:0]       n_drive, r_drive;
    logic                                n_limited, r_limited;

    assign w_max_ext = SH_W'($signed(w_cfg.drive_max));
    assign w_min_ext = SH_W'($signed(w_cfg.drive_min));

    always_comb begin
        priority if (r_acc > w_max_ext) begin
            n_drive   = w_cfg.drive_max;
            n_limited = 1'b1;
        end else if (r_acc < w_min_ext) begin
            n_drive   = w_cfg.drive_min;
            n_limited = 1'b1;
        end else begin
            n_drive   = r_acc[pidsc_pkg::DRIVE_W-1:0];
            n_limited = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_adv4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_drive   <= n_drive;
            r_limited <= n_limited;
        end
    end

    assign o_valid   = r_v4;
    assign o_drive   = r_drive;
    assign o_limited = r_limited;

`ifndef ASSERT_OFF
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v1)
        else $error("accepted request did not enter stage 1");

    a_last_error_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_last_error == $past(w_err)))
        else $error("last error not updated from accepted request");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input stalled while pipeline has a bubble");

    a_limited_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_limited) |->
            (o_drive == w_cfg.drive_max || o_drive == w_cfg.drive_min))
        else $error("limited drive not at an output bound");

    a_unlimited_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_limited
            && ($signed(w_cfg.drive_min) <= $signed(w_cfg.drive_max))) |->
            ($signed(o_drive) >= $signed(w_cfg.drive_min)
             && $signed(o_drive) <= $signed(w_cfg.drive_max)))
        else $error("unlimited drive outside output range");
`endif

endmodule

// File: bench/tb_top.sv
// self-checking testbench for the pid speed controller unit
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC        = 16;
    localparam int N_DIRECTED  = 22;
    localparam int N_PHASES    = 8;
    localparam int PHASE_TICKS = 60;
    localparam int SETTLE      = 8;
    localparam int LONG_HOLD   = 100;
    localparam int CYCLE_LIMIT = 200000;

    // indexes past the register map, writes there must change nothing
    localparam logic [pidsc_pkg::IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [pidsc_pkg::IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [31:0] drive;
        logic        limited;
    } t_drive_result;

    typedef struct packed {
        logic        typed;
        logic [31:0] drive;
        logic        limited;
    } t_tick_tag;

    typedef struct packed {
        logic [2:0]  gain_set;
        logic [15:0] target;
        logic [15:0] measured;
        logic        typed;
        logic [31:0] drive;
        logic        limited;
    } t_tick_row;

    logic                           i_clk            = 1'b0;
    logic                           i_rst_n          = 1'b0;
    logic                           i_valid          = 1'b0;
    logic                           o_stall;
    logic [15:0]                    i_target_speed   = '0;
    logic [15:0]                    i_measured_speed = '0;
    logic                           o_valid;
    logic                           i_stall          = 1'b0;
    logic [31:0]                    o_drive;
    logic                           o_limited;
    logic                           psel             = 1'b0;
    logic                           penable          = 1'b0;
    logic                           pwrite           = 1'b0;
    logic [pidsc_pkg::PADDR_W-1:0]  paddr            = '0;
    logic [pidsc_pkg::PDATA_W-1:0]  pwdata           = '0;
    logic [pidsc_pkg::PDATA_W-1:0]  prdata;
    logic                           pready;

    pid_speed_controller_unit #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_target_speed  (i_target_speed),
        .i_measured_speed(i_measured_speed),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive         (o_drive),
        .o_limited       (o_limited),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // controller copy: registers and loop state
    logic signed [31:0] kp_gain   = '0;
    logic signed [31:0] ki_gain   = '0;
    logic signed [31:0] kd_gain   = '0;
    logic        [30:0] sum_cap   = '0;
    logic signed [31:0] drive_lo  = '0;
    logic signed [31:0] drive_hi  = '0;
    logic signed [31:0] err_accum = '0;
    logic signed [16:0] prev_err  = '0;

    t_drive_result pending_drives[$];
    t_tick_tag     typed_drives[$];
    int            ticks_sent    = 0;
    int            drives_seen   = 0;
    int            mismatches    = 0;
    int            cycle_count   = 0;
    int            tx_idle_mode  = 0;
    int            rx_idle_mode  = 0;
    bit            long_hold_req = 1'b0;
    logic [15:0]   speed_base    = '0;

    pidsc_pkg::t_cfg gain_sets [8] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0,
          32'h0000_0000, 32'h0000_0000},
        '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 31'h0,
          32'h8000_0000, 32'h7FFF_FFFF},
        '{32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 31'h0,
          32'h8000_0000, 32'h7FFF_FFFF},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
          32'hFFFF_FC18, 32'h0000_03E8},
        '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 31'h0,
          32'h0000_0064, 32'hFFFF_FF9C},
        '{32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 31'd10,
          32'h8000_0000, 32'h7FFF_FFFF},
        '{32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 31'd2,
          32'h8000_0000, 32'h7FFF_FFFF}
    };

    // set 0 is the reset state, set 5 has the limits inverted
    t_tick_row directed_ticks [N_DIRECTED] = '{
        '{3'd0, 16'h0000, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        '{3'd0, 16'h7FFF, 16'h8000, 1'b1, 32'h0000_0000, 1'b0},
        '{3'd0, 16'h8000, 16'h7FFF, 1'b1, 32'h0000_0000, 1'b0},
        '{3'd1, 16'h0064, 16'h0028, 1'b1, 32'h0000_003C, 1'b0},
        '{3'd1, 16'h7FFF, 16'h8000, 1'b1, 32'h0000_FFFF, 1'b0},
        '{3'd1, 16'h8000, 16'h7FFF, 1'b1, 32'hFFFF_0001, 1'b0},
        '{3'd2, 16'h0000, 16'h0001, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{3'd2, 16'h0001, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        '{3'd2, 16'h0000, 16'h0003, 1'b1, 32'hFFFF_FFFE, 1'b0},
        '{3'd3, 16'h7FFF, 16'h8000, 1'b0, 32'h0, 1'b0},
        '{3'd3, 16'h7FFF, 16'h8000, 1'b0, 32'h0, 1'b0},
        '{3'd3, 16'h8000, 16'h7FFF, 1'b0, 32'h0, 1'b0},
        '{3'd4, 16'h8000, 16'h7FFF, 1'b0, 32'h0, 1'b0},
        '{3'd4, 16'h0000, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{3'd4, 16'h04D2, 16'hFFB3, 1'b0, 32'h0, 1'b0},
        '{3'd5, 16'h01F4, 16'h0000, 1'b1, 32'hFFFF_FF9C, 1'b1},
        '{3'd5, 16'hFE0C, 16'h0000, 1'b1, 32'h0000_0064, 1'b1},
        '{3'd5, 16'h0000, 16'h0000, 1'b1, 32'hFFFF_FF9C, 1'b1},
        '{3'd6, 16'h0032, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{3'd6, 16'hFFFD, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{3'd7, 16'h0000, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{3'd7, 16'h0007, 16'h0007, 1'b0, 32'h0, 1'b0}
    };

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pid_speed_controller_unit verification failed");
            $finish;
        end
    end

    function automatic void apply_reg_write(input logic [pidsc_pkg::PADDR_W-1:0] addr,
                                            input logic [31:0] data);
        case (addr[pidsc_pkg::PADDR_W-1:2])
            pidsc_pkg::REG_KP:         kp_gain  = data;
            pidsc_pkg::REG_KI_DT:      ki_gain  = data;
            pidsc_pkg::REG_KD_PER_DT:  kd_gain  = data;
            pidsc_pkg::REG_SUM_LIMIT:  sum_cap  = data[30:0];
            pidsc_pkg::REG_DRIVE_MIN:  drive_lo = data;
            pidsc_pkg::REG_DRIVE_MAX:  drive_hi = data;
            default: ;
        endcase
    endfunction

    // one control tick: integrate, three products, floor shift, clamp
    function automatic t_drive_result pid_tick_drive(input logic signed [15:0] tgt,
                                                     input logic signed [15:0] meas);
        longint err, sum, cap, acc, val, kp_l, ki_l, kd_l, prev_l, lo, hi;
        t_drive_result res;
        err    = tgt;
        err    = err - longint'(meas);
        sum    = err_accum;
        sum    = sum + err;
        cap    = {33'b0, sum_cap};
        if (sum > cap)
            sum = cap;
        else if (sum < -cap)
            sum = -cap;
        err_accum = sum[31:0];
        kp_l   = kp_gain;
        ki_l   = ki_gain;
        kd_l   = kd_gain;
        prev_l = prev_err;
        acc    = kp_l * err + ki_l * sum + kd_l * (err - prev_l);
        val    = acc >>> FRAC;
        lo     = drive_lo;
        hi     = drive_hi;
        res.limited = 1'b0;
        if (val > hi) begin
            val = hi;
            res.limited = 1'b1;
        end else if (val < lo) begin
            val = lo;
            res.limited = 1'b1;
        end
        res.drive = val[31:0];
        prev_err  = err[16:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_drive_result exp_res;
        t_drive_result got;
        t_tick_tag     tag;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready)
                apply_reg_write(paddr, pwdata);
            if (i_valid && !o_stall) begin
                exp_res = pid_tick_drive(i_target_speed, i_measured_speed);
                tag = (typed_drives.size() != 0) ? typed_drives.pop_front() : '0;
                if (tag.typed) begin
                    exp_res.drive   = tag.drive;
                    exp_res.limited = tag.limited;
                end
                pending_drives.push_back(exp_res);
            end
            if (o_valid && !i_stall) begin
                drives_seen++;
                if (pending_drives.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected drive result %0d", $time, $signed(o_drive));
                end else begin
                    got = pending_drives.pop_front();
                    if (o_drive !== got.drive) begin
                        mismatches++;
                        $display("%0t: drive expected %0d got %0d", $time,
                                 $signed(got.drive), $signed(o_drive));
                    end
                    if (o_limited !== got.limited) begin
                        mismatches++;
                        $display("%0t: limited expected %0b got %0b", $time,
                                 got.limited, o_limited);
                    end
                end
            end
        end
    end

    // receiver side, random stall bursts and the one long hold-off
    initial begin
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (rx_idle_mode != 0 &&
                         $urandom_range(0, rx_idle_mode == 1 ? 7 : 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic apb_write(input logic [pidsc_pkg::IDX_W-1:0] idx,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_gains(input pidsc_pkg::t_cfg g);
        apb_write(pidsc_pkg::REG_KP, g.kp);
        apb_write(pidsc_pkg::REG_KI_DT, g.ki_dt);
        apb_write(pidsc_pkg::REG_KD_PER_DT, g.kd_per_dt);
        apb_write(pidsc_pkg::REG_SUM_LIMIT, {1'b0, g.error_sum_limit});
        apb_write(pidsc_pkg::REG_DRIVE_MIN, g.drive_min);
        apb_write(pidsc_pkg::REG_DRIVE_MAX, g.drive_max);
        apb_write(REG_SPARE_A, $urandom());
        apb_write(REG_SPARE_B, $urandom());
    endtask

    // sender side, optional gap then hold the request until taken
    task automatic offer_tick(input logic [15:0] tgt, input logic [15:0] meas);
        if (tx_idle_mode != 0 && $urandom_range(0, tx_idle_mode == 1 ? 7 : 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_target_speed   <= tgt;
        i_measured_speed <= meas;
        do @(posedge i_clk); while (o_stall);
        ticks_sent++;
    endtask

    // stop offering and let every outstanding request come back
    task automatic settle();
        i_valid <= 1'b0;
        while (drives_seen < ticks_sent) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'h60000)) - 32'h30000;
            2: begin
                case ($urandom_range(0, 2))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    default: return 32'h0;
                endcase
            end
            default: return 32'($urandom_range(0, 32'h20000));
        endcase
    endfunction

    function automatic pidsc_pkg::t_cfg build_gain_set();
        pidsc_pkg::t_cfg g;
        logic signed [31:0] a, b, t;
        g.kp        = pick_gain();
        g.ki_dt     = pick_gain();
        g.kd_per_dt = pick_gain();
        case ($urandom_range(0, 3))
            0:       g.error_sum_limit = 31'($urandom());
            1:       g.error_sum_limit = 31'($urandom_range(0, 5000));
            2:       g.error_sum_limit = 31'h0;
            default: g.error_sum_limit = 31'h7FFF_FFFF;
        endcase
        a = $urandom();
        b = $urandom();
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        case ($urandom_range(0, 3))
            0: begin
                g.drive_min = 32'h8000_0000;
                g.drive_max = 32'h7FFF_FFFF;
            end
            1: begin
                g.drive_min = a;
                g.drive_max = b;
            end
            2: begin
                g.drive_min = b;
                g.drive_max = a;
            end
            default: begin
                g.drive_min = -32'sd1 * $signed(32'($urandom_range(0, 5000)));
                g.drive_max = 32'($urandom_range(0, 5000));
            end
        endcase
        return g;
    endfunction

    function automatic logic [15:0] corner_speed();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    initial begin
        int          cur_set;
        t_tick_row   row;
        t_tick_tag   row_tag;
        logic [15:0] tgt;
        logic [15:0] meas;
        cur_set = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_mode = 1;
        rx_idle_mode = 1;
        for (int r = 0; r < N_DIRECTED; r++) begin
            row = directed_ticks[r];
            if (int'(row.gain_set) != cur_set) begin
                settle();
                cur_set = row.gain_set;
                load_gains(gain_sets[cur_set]);
            end
            row_tag.typed   = row.typed;
            row_tag.drive   = row.drive;
            row_tag.limited = row.limited;
            typed_drives.push_back(row_tag);
            offer_tick(row.target, row.measured);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            load_gains(build_gain_set());
            speed_base   = 16'($urandom_range(0, 4000)) - 16'd2000;
            tx_idle_mode = $urandom_range(0, 2);
            rx_idle_mode = $urandom_range(0, 2);
            if (p == 1) begin
                // keep offering while the output is held so the pipe backs up
                tx_idle_mode  = 0;
                rx_idle_mode  = 1;
                long_hold_req = 1'b1;
            end
            if (p == N_PHASES - 1) begin
                tx_idle_mode = 0;
                rx_idle_mode = 0;
            end
            for (int n = 0; n < PHASE_TICKS; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        tgt  = speed_base + 16'($urandom_range(0, 64)) - 16'd32;
                        meas = tgt + 16'($urandom_range(0, 400)) - 16'd200;
                    end
                    4, 5, 6, 7, 8: begin
                        tgt  = 16'($urandom());
                        meas = 16'($urandom());
                    end
                    default: begin
                        tgt  = corner_speed();
                        meas = corner_speed();
                    end
                endcase
                typed_drives.push_back('0);
                offer_tick(tgt, meas);
            end
        end

        settle();
        if (mismatches == 0 && pending_drives.size() == 0)
            $display("pid_speed_controller_unit verification clean");
        else
            $display("pid_speed_controller_unit verification failed");
        $finish;
    end

endmodule
